>>> design/signed_int_to_decimal_ascii_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SITDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sitda_pkg.sv
package sitda_pkg;

    localparam int MAG_W   = 32;
    localparam int DIG_N   = 10;
    localparam int BCD_W   = 4 * DIG_N;
    localparam int CNT_W   = $clog2(MAG_W + 1);
    localparam int IDX_W   = $clog2(DIG_N);
    localparam int CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [DIG_N-1:0][3:0] t_bcd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // One output beat from the character sequencer.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

endpackage

>>> design/sitda_bcd.sv
module sitda_bcd (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [sitda_pkg::MAG_W-1:0] i_mag,
    output logic                  o_busy,
    output sitda_pkg::t_bcd       o_bcd
);
    import sitda_pkg::*;

    logic [MAG_W-1:0] r_mag, n_mag;
    t_bcd             r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_bcd             adj;

    // add-3 on every digit >= 5, then shift one magnitude bit in
    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_load) begin
            n_mag = i_mag;
            n_bcd = '0;
            n_cnt = CNT_W'(MAG_W);
        end else if (r_cnt != '0) begin
            // top bit of the adjusted digits falls off, magnitude msb enters at bit 0
            n_bcd = BCD_W'({adj, r_mag[MAG_W-1]});
            n_mag = {r_mag[MAG_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_bcd  = r_bcd;

endmodule

>>> design/sitda_emit.sv
module sitda_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_negative,
    input  sitda_pkg::t_bcd        i_bcd,
    output sitda_pkg::t_char_beat  o_beat
);
    import sitda_pkg::*;

    t_bcd             r_bcd;
    logic             r_active, n_active;
    logic             r_sign, n_sign;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] msd;
    logic             last;

    // most significant nonzero digit; zero keeps index 0
    always_comb begin
        msd = '0;
        for (int i = 0; i < DIG_N; i++) begin
            if (i_bcd[i] != 4'd0) begin
                msd = IDX_W'(i);
            end
        end
    end

    assign last = !r_sign && (r_idx == '0);

    always_comb begin
        n_active = r_active;
        n_sign   = r_sign;
        n_idx    = r_idx;
        o_beat   = '0;
        if (i_load) begin
            n_active = 1'b1;
            n_sign   = i_negative;
            n_idx    = msd;
        end else if (r_active) begin
            o_beat.valid = 1'b1;
            o_beat.last  = last;
            if (r_sign) begin
                o_beat.code = CHAR_MINUS;
                n_sign      = 1'b0;
            end else begin
                o_beat.code = CHAR_ZERO + {2'b00, r_bcd[r_idx]};
                if (last) begin
                    n_active = 1'b0;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bcd <= i_bcd;
        end
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sign   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_sign   <= n_sign;
        end
    end

endmodule

>>> design/signed_int_to_decimal_ascii_unit.sv
// The first character follows the load and the 32 shift/add-3 steps of the binary-to-BCD loop.
// An item producing n characters (1..11) holds busy through its last character.
// No new start is taken while an item is in progress; the next start is taken the cycle
// after the last char.
// Rate is set by the bit-serial binary-to-BCD loop, then one character per cycle.
// Reset (i_rst_n low, synchronous) drops busy and o_valid; the receiver cannot stall.
module signed_int_to_decimal_ascii_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [sitda_pkg::MAG_W-1:0] i_value,
    output logic                          o_valid,
    output logic [sitda_pkg::CHAR_W-1:0]  o_char_code,
    output logic                          o_last_char
);
    import sitda_pkg::*;

    t_state           r_state, n_state;
    logic             r_neg;
    logic             accept;
    logic [MAG_W-1:0] mag;
    logic             bcd_busy;
    t_bcd             bcd;
    logic             emit_load;
    t_char_beat       beat;

    assign accept = start && !busy;
    // two's complement negate, exact for the most negative value
    assign mag    = i_value[MAG_W-1] ? (~i_value + 1'b1) : i_value;

    always_comb begin
        n_state   = r_state;
        busy      = 1'b1;
        emit_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!bcd_busy) begin
                    emit_load = 1'b1;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (beat.valid && beat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[MAG_W-1];
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    sitda_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_mag   (mag),
        .o_busy  (bcd_busy),
        .o_bcd   (bcd)
    );

    sitda_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit_load),
        .i_negative (r_neg),
        .i_bcd      (bcd),
        .o_beat     (beat)
    );

    assign o_valid     = beat.valid;
    assign o_char_code = beat.code;
    assign o_last_char = beat.last;

endmodule

>>> design/sitda_checker.sv
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module sitda_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [sitda_pkg::CHAR_W-1:0]  o_char_code,
    input logic                          o_last_char
);
    import sitda_pkg::*;

    logic code_ok;

    assign code_ok = (o_char_code == CHAR_MINUS) ||
                     ((o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_ZERO + 6'd9));

    `SITDA_ASSERT_NOW(a_beat_in_item, i_clk, i_rst_n, o_valid, busy, "beat outside busy window")
    `SITDA_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, start && !busy, busy && !o_valid, "beat right after accept")
    `SITDA_ASSERT_NOW(a_last_marked, i_clk, i_rst_n, o_last_char, o_valid, "last flag without beat")
    `SITDA_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_valid, code_ok, "bad character code")
    `SITDA_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_valid && o_last_char, !busy, "busy after last beat")

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);
